/* design/sliding_window_mode_sum_unit_defines.svh */
// assertion macros for the sliding window mode sum unit
// needs i_clk and i_rst_n in the scope where a macro is used
`ifndef SLIDING_WINDOW_MODE_SUM_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MODE_SUM_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SWMS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SWMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/swms_pkg.sv */
// shared types and constants for the sliding window mode sum unit
// no dependencies
package swms_pkg;

    // window depth and sample format
    localparam int WIN_MAX     = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int SAMPLE_W    = 16;
    localparam int CNT_W       = $clog2(WIN_MAX + 1);
    localparam int IDX_W       = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
    localparam int WSZ_W       = 7;
    localparam int SUM_W       = 48;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // command codes
    localparam logic CMD_PUSH    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [WSZ_W-1:0]    t_wsz;
    typedef logic [SUM_W-1:0]    t_sum;

    // classified operation
    typedef struct packed {
        logic    restart;
        t_sample sample;
    } t_op;

    // queue head seen by the back end
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_q_if;

    // back end status
    typedef struct packed {
        logic busy;
        logic emit;
    } t_back_stat;

endpackage

/* design/swms_front.sv */
// front end: accepts input transfers, classifies them and queues them
// depends on swms_pkg
module swms_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  swms_pkg::t_sample  i_sample,
    output swms_pkg::t_q_if    o_q,
    input  logic               i_q_pop
);
    import swms_pkg::*;

    t_op               r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_fill, n_fill;
    t_op               op_in;
    logic              push;
    logic              pop;

    // classify the incoming transfer
    always_comb begin
        op_in.restart = (i_command == CMD_RESTART);
        op_in.sample  = op_in.restart ? '0 : (i_sample & SAMPLE_MASK);
    end

    assign o_ready  = (r_fill != QCNT_W'(QDEPTH));
    assign push     = i_valid && o_ready;
    assign pop      = i_q_pop && (r_fill != '0);
    assign o_q.valid = (r_fill != '0);
    assign o_q.op    = r_q[r_rd_ptr];

    // pointer and fill update
    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_fill   = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + QCNT_W'(1);
        end else if (pop && !push) begin
            n_fill = r_fill - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= op_in;
        end
    end

endmodule

/* design/swms_back.sv */
// back end: window shift line, per-slot counters, mode sweep, output register
// depends on swms_pkg
module swms_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  swms_pkg::t_q_if      i_q,
    output logic                 o_q_pop,
    input  swms_pkg::t_cnt       i_win_eff,
    output logic                 o_valid,
    input  logic                 i_ready,
    output swms_pkg::t_sample    o_mode_value,
    output swms_pkg::t_cnt       o_mode_count,
    output swms_pkg::t_sum       o_mode_sum,
    output swms_pkg::t_back_stat o_stat
);
    import swms_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_COUNT  = 2'd1;
    localparam logic [1:0] ST_SELECT = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]       r_state, n_state;
    t_sample          r_win  [WIN_MAX];
    t_sample          n_win  [WIN_MAX];
    t_sample          r_scan [WIN_MAX];
    t_sample          n_scan [WIN_MAX];
    t_cnt             r_cnt  [WIN_MAX];
    t_cnt             n_cnt  [WIN_MAX];
    t_cnt             r_fill, n_fill;
    t_cnt             r_n, n_n;
    logic [IDX_W-1:0] r_step, n_step;
    t_sum             r_sum, n_sum;
    t_sample          r_best_val, n_best_val;
    t_cnt             r_best_cnt, n_best_cnt;
    logic             r_out_valid, n_out_valid;
    t_sample          r_out_val, n_out_val;
    t_cnt             r_out_cnt, n_out_cnt;
    t_sum             r_out_sum, n_out_sum;
    logic             out_free;
    logic             last_step;
    t_cnt             fill_inc;
    logic             take;

    assign out_free  = !r_out_valid || i_ready;
    assign last_step = (CNT_W'(r_step) == (r_n - CNT_W'(1)));
    assign fill_inc  = (r_fill == CNT_W'(WIN_MAX)) ? r_fill : r_fill + CNT_W'(1);
    assign take      = (r_cnt[0] > r_best_cnt) ||
                       ((r_cnt[0] == r_best_cnt) && (r_scan[0] < r_best_val));

    assign o_q_pop      = (r_state == ST_IDLE) && i_q.valid;
    assign o_valid      = r_out_valid;
    assign o_mode_value = r_out_val;
    assign o_mode_count = r_out_cnt;
    assign o_mode_sum   = r_out_sum;
    assign o_stat.busy  = (r_state != ST_IDLE);
    assign o_stat.emit  = (r_state == ST_EMIT) && out_free;

    // sequencer and datapath next state
    always_comb begin
        n_state     = r_state;
        n_win       = r_win;
        n_scan      = r_scan;
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_n         = r_n;
        n_step      = r_step;
        n_sum       = r_sum;
        n_best_val  = r_best_val;
        n_best_cnt  = r_best_cnt;
        n_out_valid = r_out_valid;
        n_out_val   = r_out_val;
        n_out_cnt   = r_out_cnt;
        n_out_sum   = r_out_sum;

        // output transfer frees the register
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_q.valid) begin
                    if (i_q.op.restart) begin
                        n_fill = '0;
                        n_sum  = '0;
                    end else begin
                        // shift the new sample into slot zero
                        n_win[0] = i_q.op.sample;
                        for (int i = 1; i < WIN_MAX; i++) begin
                            n_win[i] = r_win[i-1];
                        end
                        n_fill = fill_inc;
                        if (fill_inc >= i_win_eff) begin
                            n_scan = n_win;
                            for (int i = 0; i < WIN_MAX; i++) begin
                                n_cnt[i] = '0;
                            end
                            n_step  = '0;
                            n_n     = i_win_eff;
                            n_state = ST_COUNT;
                        end
                    end
                end
            end
            ST_COUNT: begin
                // every active slot matching the scan head gains one
                for (int i = 0; i < WIN_MAX; i++) begin
                    if ((CNT_W'(i) < r_n) && (r_win[i] == r_scan[0])) begin
                        n_cnt[i] = r_cnt[i] + CNT_W'(1);
                    end
                end
                for (int k = 0; k < WIN_MAX - 1; k++) begin
                    n_scan[k] = r_scan[k+1];
                end
                if (last_step) begin
                    n_scan     = r_win;
                    n_step     = '0;
                    n_best_val = '0;
                    n_best_cnt = '0;
                    n_state    = ST_SELECT;
                end else begin
                    n_step = r_step + IDX_W'(1);
                end
            end
            ST_SELECT: begin
                // walk slots in order, keep highest count, smaller value on ties
                if (take) begin
                    n_best_val = r_scan[0];
                    n_best_cnt = r_cnt[0];
                end
                for (int k = 0; k < WIN_MAX - 1; k++) begin
                    n_scan[k] = r_scan[k+1];
                    n_cnt[k]  = r_cnt[k+1];
                end
                if (last_step) begin
                    n_state = ST_EMIT;
                end else begin
                    n_step = r_step + IDX_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_val   = r_best_val;
                    n_out_cnt   = r_best_cnt;
                    n_out_sum   = r_sum + SUM_W'(r_best_val);
                    n_sum       = r_sum + SUM_W'(r_best_val);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_win      <= n_win;
        r_scan     <= n_scan;
        r_cnt      <= n_cnt;
        r_n        <= n_n;
        r_step     <= n_step;
        r_best_val <= n_best_val;
        r_best_cnt <= n_best_cnt;
        r_out_val  <= n_out_val;
        r_out_cnt  <= n_out_cnt;
        r_out_sum  <= n_out_sum;
    end

endmodule

/* design/sliding_window_mode_sum_unit.sv */
// top level of the sliding window mode sum unit: window size register, front, back
// depends on swms_pkg, swms_front, swms_back and the assertion macro header
//
//   channel   handshake               payload
//   input     i_valid / o_ready       i_command, i_sample
//   output    o_valid / i_ready       o_mode_value, o_mode_count, o_mode_sum
//   config    i_cfg_wr_en             i_cfg_wr_data
//
// a push that yields a result runs through the back end states in order, W the
// effective window size: parallel slot counting against each of the W samples, mode sweep over the W slots, emit
// a restart, or a push while the window fills, is handled in the idle state alone
// a two-entry queue lets input transfers land while the back end works
// the output register holds a result until taken; the back end waits only to load it
// synchronous active-low reset, no clearing pass: the fill level marks valid slots
`include "sliding_window_mode_sum_unit_defines.svh"

module sliding_window_mode_sum_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_command,
    input  swms_pkg::t_sample   i_sample,
    output logic                o_valid,
    input  logic                i_ready,
    output swms_pkg::t_sample   o_mode_value,
    output swms_pkg::t_cnt      o_mode_count,
    output swms_pkg::t_sum      o_mode_sum,
    input  logic                i_cfg_wr_en,
    input  swms_pkg::t_wsz      i_cfg_wr_data
);
    import swms_pkg::*;

    t_wsz       r_window_size;
    t_cnt       win_eff;
    t_q_if      q_head;
    logic       q_pop;
    t_back_stat back_stat;

    // window size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WSZ_W'(1);
        end else if (i_cfg_wr_en) begin
            r_window_size <= i_cfg_wr_data;
        end
    end

    // clamp window size to one through the window depth
    always_comb begin
        if (r_window_size == '0) begin
            win_eff = CNT_W'(1);
        end else if (int'(r_window_size) > WIN_MAX) begin
            win_eff = CNT_W'(WIN_MAX);
        end else begin
            win_eff = CNT_W'(r_window_size);
        end
    end

    swms_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_command (i_command),
        .i_sample  (i_sample),
        .o_q       (q_head),
        .i_q_pop   (q_pop)
    );

    swms_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q          (q_head),
        .o_q_pop      (q_pop),
        .i_win_eff    (win_eff),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_mode_value (o_mode_value),
        .o_mode_count (o_mode_count),
        .o_mode_sum   (o_mode_sum),
        .o_stat       (back_stat)
    );

    // checks on the back end and the result
    `SWMS_ASSERT_IMPL(a_count_range, o_valid, (o_mode_count != '0) && (o_mode_count <= win_eff), "mode count outside the window")
    `SWMS_ASSERT_IMPL(a_pop_nonempty, q_pop, q_head.valid, "queue popped while empty")
    `SWMS_ASSERT_IMPL(a_pop_idle, q_pop, !back_stat.busy, "queue popped while back end busy")
    `SWMS_ASSERT_NEXT(a_emit_loads, back_stat.emit, o_valid, "emitted result not presented")
    `SWMS_ASSERT_IMPL(a_rise_from_emit, $rose(o_valid), $past(back_stat.emit), "result without emit")

endmodule

/* tb/sv/tb_sliding_window_mode_sum_unit.sv */
// self-checking testbench for sliding_window_mode_sum_unit: directed table, then random phases
// predicts window mode, count and running sum per sample transfer and checks each result
// depends on swms_pkg and the sliding_window_mode_sum_unit rtl
module tb_sliding_window_mode_sum_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import swms_pkg::*;

    // back end of one window at the largest size, two queued items, plus margin
    localparam int IDLE_CYCLES     = 3 * (2 * WIN_MAX + 2) + 16;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int N_PHASES        = 12;
    localparam int N_DIRECTED      = 28;

    typedef enum logic [0:0] {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_sample value;
        t_cnt    count;
        t_sum    total;
    } t_mode_result;

    typedef struct packed {
        t_row_kind kind;
        logic      cmd;
        t_sample   smp;
        t_wsz      wsz;
        logic      typed;
        t_sample   value;
        t_cnt      count;
        t_sum      total;
    } t_dir_row;

    // directed rows: typed results only where they follow at a glance
    localparam t_dir_row DIRECTED [N_DIRECTED] = '{
        '{ROW_ITEM, CMD_RESTART, 16'h0000, 7'd0,   1'b0, 16'h0000, 7'd0, 48'h0},
        '{ROW_ITEM, CMD_PUSH,    16'h0000, 7'd0,   1'b1, 16'h0000, 7'd1, 48'h0},
        '{ROW_ITEM, CMD_PUSH,    16'hFFFF, 7'd0,   1'b1, 16'hFFFF, 7'd1, 48'hFFFF},
        '{ROW_ITEM, CMD_PUSH,    16'h0001, 7'd0,   1'b1, 16'h0001, 7'd1, 48'h10000},
        '{ROW_ITEM, CMD_RESTART, 16'hFFFF, 7'd0,   1'b0, 16'h0000, 7'd0, 48'h0},
        '{ROW_ITEM, CMD_PUSH,    16'h0005, 7'd0,   1'b1, 16'h0005, 7'd1, 48'h5},
        '{ROW_CFG,  CMD_PUSH,    16'h0000, 7'd0,   1'b0, 16'h0000, 7'd0, 48'h0},
        '{ROW_ITEM, CMD_PUSH,    16'h0007, 7'd0,   1'b1, 16'h0007, 7'd1, 48'hC},
        '{ROW_CFG,  CMD_PUSH,    16'h0000, 7'd3,   1'b0, 16'h0000, 7'd0, 48'h0},
        '{ROW_ITEM, CMD_RESTART, 16'h0000, 7'd0,   1'b0, 16'h0000, 7'd0, 48'h0},
        '{ROW_ITEM, CMD_PUSH,    16'h0009, 7'd0,   1'b0, 16'h0000, 7'd0, 48'h0},
        '{ROW_ITEM, CMD_PUSH,    16'h0004, 7'd0,   1'b0, 16'h0000, 7'd0, 48'h0},
        '{ROW_ITEM, CMD_PUSH,    16'h0009, 7'd0,   1'b1, 16'h0009, 7'd2, 48'h9},
        '{ROW_ITEM, CMD_PUSH,    16'h0004, 7'd0,   1'b1, 16'h0004, 7'd2, 48'hD},
        '{ROW_ITEM, CMD_PUSH,    16'h0002, 7'd0,   1'b1, 16'h0002, 7'd1, 48'hF},
        '{ROW_CFG,  CMD_PUSH,    16'h0000, 7'd2,   1'b0, 16'h0000, 7'd0, 48'h0},
        '{ROW_ITEM, CMD_PUSH,    16'h0008, 7'd0,   1'b0, 16'h0000, 7'd0, 48'h0},
        '{ROW_ITEM, CMD_PUSH,    16'h0008, 7'd0,   1'b0, 16'h0000, 7'd0, 48'h0},
        '{ROW_ITEM, CMD_RESTART, 16'h0000, 7'd0,   1'b0, 16'h0000, 7'd0, 48'h0},
        '{ROW_ITEM, CMD_PUSH,    16'hFFFF, 7'd0,   1'b0, 16'h0000, 7'd0, 48'h0},
        '{ROW_ITEM, CMD_PUSH,    16'hFFFF, 7'd0,   1'b1, 16'hFFFF, 7'd2, 48'hFFFF},
        '{ROW_CFG,  CMD_PUSH,    16'h0000, 7'd1,   1'b0, 16'h0000, 7'd0, 48'h0},
        '{ROW_ITEM, CMD_PUSH,    16'h0000, 7'd0,   1'b1, 16'h0000, 7'd1, 48'hFFFF},
        '{ROW_CFG,  CMD_PUSH,    16'h0000, 7'd127, 1'b0, 16'h0000, 7'd0, 48'h0},
        '{ROW_ITEM, CMD_PUSH,    16'h8000, 7'd0,   1'b0, 16'h0000, 7'd0, 48'h0},
        '{ROW_CFG,  CMD_PUSH,    16'h0000, 7'd64,  1'b0, 16'h0000, 7'd0, 48'h0},
        '{ROW_ITEM, CMD_RESTART, 16'h0000, 7'd0,   1'b0, 16'h0000, 7'd0, 48'h0},
        '{ROW_ITEM, CMD_PUSH,    16'h7FFF, 7'd0,   1'b0, 16'h0000, 7'd0, 48'h0}
    };

    // dut signals, inputs known from time zero
    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         i_valid       = 1'b0;
    logic         o_ready;
    logic         i_command     = CMD_PUSH;
    t_sample      i_sample      = '0;
    logic         o_valid;
    logic         i_ready       = 1'b0;
    t_sample      o_mode_value;
    t_cnt         o_mode_count;
    t_sum         o_mode_sum;
    logic         i_cfg_wr_en   = 1'b0;
    t_wsz         i_cfg_wr_data = '0;

    // side info that travels with the payload of the current transfer
    logic         row_typed  = 1'b0;
    t_mode_result row_expect = '0;

    // window model
    t_sample      win_q [WIN_MAX];
    int unsigned  fill_cnt  = 0;
    t_sum         mode_total = '0;
    t_wsz         win_cfg   = 7'd1;

    t_mode_result pending_modes [$];
    int unsigned  mismatches   = 0;
    logic         sender_quiet = 1'b0;

    sliding_window_mode_sum_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_mode_value  (o_mode_value),
        .o_mode_count  (o_mode_count),
        .o_mode_sum    (o_mode_sum),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // clear the window, counts and sum
    function automatic void clear_window_model();
        for (int i = 0; i < WIN_MAX; i++) win_q[i] = '0;
        fill_cnt   = 0;
        mode_total = '0;
    endfunction

    // shift one sample in and work out the mode, returns 1 when a result is due
    function automatic bit advance_window(input logic cmd, input t_sample smp,
                                          output t_mode_result res);
        int      w;
        int      cnt;
        int      best_cnt;
        t_sample best_val;
        res = '0;
        if (cmd == CMD_RESTART) begin
            clear_window_model();
            return 1'b0;
        end
        for (int i = WIN_MAX - 1; i > 0; i--) win_q[i] = win_q[i-1];
        win_q[0] = smp & SAMPLE_MASK;
        if (fill_cnt < WIN_MAX) fill_cnt++;
        // zero acts as one, oversize saturates at the depth
        w = (win_cfg == 0) ? 1 : ((int'(win_cfg) > WIN_MAX) ? WIN_MAX : int'(win_cfg));
        if (fill_cnt < w) return 1'b0;
        best_cnt = 0;
        best_val = '0;
        for (int i = 0; i < w; i++) begin
            cnt = 0;
            for (int j = 0; j < w; j++)
                if (win_q[j] == win_q[i]) cnt++;
            if (cnt > best_cnt || (cnt == best_cnt && win_q[i] < best_val)) begin
                best_cnt = cnt;
                best_val = win_q[i];
            end
        end
        mode_total = mode_total + t_sum'(best_val);
        res.value  = best_val;
        res.count  = t_cnt'(best_cnt);
        res.total  = mode_total;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    // scoreboard: results first, then config and input transfers of the same edge
    always @(posedge i_clk) begin : score
        t_mode_result want;
        t_mode_result calc;
        if (!i_rst_n) begin
            clear_window_model();
            win_cfg = 7'd1;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_modes.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected, value 0x%0h count %0d sum 0x%0h",
                             $time, o_mode_value, o_mode_count, o_mode_sum);
                end else begin
                    want = pending_modes.pop_front();
                    check_field("mode_value", want.value, o_mode_value);
                    check_field("mode_count", want.count, o_mode_count);
                    check_field("mode_sum",   want.total, o_mode_sum);
                end
            end
            if (i_cfg_wr_en) win_cfg = i_cfg_wr_data;
            if (i_valid && o_ready) begin
                if (advance_window(i_command, i_sample, calc))
                    pending_modes.push_back(row_typed ? row_expect : calc);
            end
        end
    end

    // receiver stalls: modes of no, light and heavy back pressure
    int unsigned rx_mode      = 0;
    int unsigned rx_mode_left = 0;
    int unsigned stall_left   = 0;

    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(100, 400);
        end else begin
            rx_mode_left--;
        end
        if (stall_left != 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (rx_mode != 0 && $urandom_range(0, 9) < rx_mode * 2) begin
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                       : $urandom_range(0, 3);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // present one item and hold it until the transfer
    task automatic send_item(input logic cmd, input t_sample smp, input logic typed,
                             input t_mode_result expect_res);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_sample   <= smp;
        row_typed  <= typed;
        row_expect <= expect_res;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // stop sending and wait until every expected result has arrived
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_modes.size() != 0) @(posedge i_clk);
    endtask

    // register write only with the block idle
    task automatic write_window_size(input t_wsz wsz);
        drain_results();
        repeat (IDLE_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= wsz;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // timeout
    initial begin
        #25_000_000;
        $display("FAIL sliding_window_mode_sum_unit");
        $finish;
    end

    // stimulus
    initial begin : stim
        t_wsz         phase_sizes [N_PHASES];
        t_sample      pool [6];
        int           pool_n;
        int           r;
        t_mode_result row_res;
        t_sample      smp;

        phase_sizes = '{7'd2, 7'd127, 7'd5, 7'd0, 7'd65, 7'd3, 7'd17, 7'd64, 7'd1, 7'd8,
                        7'd0, 7'd0};
        phase_sizes[10] = t_wsz'($urandom_range(1, 64));
        phase_sizes[11] = t_wsz'($urandom_range(0, 127));

        // hold synchronous reset, then release it
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int k = 0; k < N_DIRECTED; k++) begin
            if (DIRECTED[k].kind == ROW_CFG) begin
                write_window_size(DIRECTED[k].wsz);
            end else begin
                row_res = '{DIRECTED[k].value, DIRECTED[k].count, DIRECTED[k].total};
                send_item(DIRECTED[k].cmd, DIRECTED[k].smp, DIRECTED[k].typed, row_res);
            end
        end

        // random phases, each with its own window size and value pool
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_window_size(phase_sizes[ph]);
            sender_quiet = (ph % 4 == 3);
            pool_n = $urandom_range(1, 6);
            for (int p = 0; p < pool_n; p++) begin
                r = $urandom_range(0, 7);
                pool[p] = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF
                                              : t_sample'($urandom_range(0, 65535));
            end
            if ($urandom_range(0, 1) == 1) send_item(CMD_RESTART, '0, 1'b0, '0);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                r = $urandom_range(0, 199);
                if (r < 2) begin
                    send_item(CMD_RESTART, t_sample'($urandom()), 1'b0, '0);
                end else begin
                    smp = (r < 30) ? t_sample'($urandom()) : pool[$urandom_range(0, pool_n - 1)];
                    send_item(CMD_PUSH, smp, 1'b0, '0);
                end
                // occasional hold-off until the output side catches up
                if ($urandom_range(0, 63) == 0) drain_results();
            end
        end
        sender_quiet = 1'b0;

        // wind down
        drain_results();
        repeat (IDLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS sliding_window_mode_sum_unit");
        end else begin
            $display("FAIL sliding_window_mode_sum_unit");
        end
        $finish;
    end

endmodule
